### rtl/dpis_pkg.sv
`default_nettype none
package dpis_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_ACC_RD,
        S_ACC_WAIT,
        S_MLOAD,
        S_MPP,
        S_MADD,
        S_NORM,
        S_ROUND,
        S_RES,
        S_DNORM,
        S_DIV,
        S_OUT
    } st_t;

    typedef enum logic [1:0] {
        PH_SQR,
        PH_ACC,
        PH_DIV
    } ph_t;

    localparam logic [63:0] ONE_BITS   = 64'h3FF0000000000000;
    localparam logic [63:0] QNAN_DEF   = 64'hFFF8000000000000;
    localparam logic [63:0] QUIET_BIT  = 64'h0008000000000000;
    localparam logic [10:0] EXP_MAX    = 11'h7FF;
    localparam logic [5:0]  DIV_LAST   = 6'd54;
    localparam logic [1:0]  PP_LAST    = 2'd3;

endpackage
`default_nettype wire

### rtl/double_pow_int_by_squaring.sv
// Binary64 power by repeated squaring: s_tdata carries the base (bits 63:0) and
// a signed exponent (bits 95:64); m_tdata returns the binary64 result.
// One item is in flight at a time: s_tready is high only while the sequencer
// is idle, and an item is taken when s_tvalid and s_tready are both high.
// Every multiply runs through one 27 x 27 multiplier that builds a 53 x 53
// significand product from four partial products, followed by a bit-serial
// normalise and one rounding step. With h the position of the highest set
// exponent bit and n the number of set bits, an item takes h squarings and
// n further multiplies; a negative exponent adds a radix-2 reciprocal of 55
// steps. A zero exponent returns 1.0 without any multiply.
// The result waits in an output register, so the next item is taken while it
// is still unread; a stalled receiver holds m_tdata and, once a further result
// is ready, keeps the sequencer waiting. Reset empties the output register and
// returns the sequencer to idle; the term store needs no clearing.
`default_nettype none
module double_pow_int_by_squaring_unit #(
    parameter int EXP_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // base_bits [63:0], exponent [95:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // result_bits [63:0]
);

    localparam int W  = EXP_BITS;
    localparam int IW = (W > 1) ? $clog2(W) : 1;

    dpis_pkg::st_t state_reg, state_next;
    dpis_pkg::ph_t phase_reg, phase_next;

    logic [W-1:0]         mag_reg, mag_next;
    logic [W-1:0]         msh_reg, msh_next;
    logic                 neg_reg, neg_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [63:0]          sq_reg, sq_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          opa_reg, opa_next;
    logic [63:0]          opb_reg, opb_next;
    logic [52:0]          ma_reg, ma_next;
    logic [52:0]          mb_reg, mb_next;
    logic [1:0]           k_reg, k_next;
    logic [53:0]          pp_reg, pp_next;
    logic [105:0]         p_reg, p_next;
    logic                 stk_reg, stk_next;
    logic signed [12:0]   e_reg, e_next;
    logic                 sgn_reg, sgn_next;
    logic [52:0]          md_reg, md_next;
    logic signed [12:0]   ed_reg, ed_next;
    logic [53:0]          rem_reg, rem_next;
    logic [54:0]          q_reg, q_next;
    logic [5:0]           dcnt_reg, dcnt_next;
    logic [63:0]          res_reg, res_next;
    logic                 ovalid_reg, ovalid_next;
    logic [63:0]          odata_reg, odata_next;

    logic [63:0] term_mem [0:W-1];
    logic [63:0] rd_reg;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0] mem_wdata;

    // Input decode.
    logic [63:0]  exp_ext;
    logic [W-1:0] raw_exp;
    logic         raw_neg;
    logic [W-1:0] raw_mag;

    assign exp_ext = {{32{s_tdata[95]}}, s_tdata[95:64]};
    assign raw_exp = exp_ext[W-1:0];
    assign raw_neg = raw_exp[W-1];
    assign raw_mag = raw_neg ? (~raw_exp + {{(W-1){1'b0}}, 1'b1}) : raw_exp;

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == dpis_pkg::S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    // Multiply operand decode.
    logic        a_s, b_s;
    logic [10:0] a_e, b_e;
    logic [51:0] a_f, b_f;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        spec;
    logic [63:0] spec_val;

    always_comb
    begin
        a_s    = opa_reg[63];
        b_s    = opb_reg[63];
        a_e    = opa_reg[62:52];
        b_e    = opb_reg[62:52];
        a_f    = opa_reg[51:0];
        b_f    = opb_reg[51:0];
        a_nan  = (a_e == dpis_pkg::EXP_MAX) && (a_f != 52'd0);
        b_nan  = (b_e == dpis_pkg::EXP_MAX) && (b_f != 52'd0);
        a_inf  = (a_e == dpis_pkg::EXP_MAX) && (a_f == 52'd0);
        b_inf  = (b_e == dpis_pkg::EXP_MAX) && (b_f == 52'd0);
        a_zero = (a_e == 11'd0) && (a_f == 52'd0);
        b_zero = (b_e == 11'd0) && (b_f == 52'd0);
        spec   = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
        priority if (a_nan)
            spec_val = opa_reg | dpis_pkg::QUIET_BIT;
        else if (b_nan)
            spec_val = opb_reg | dpis_pkg::QUIET_BIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf))
            spec_val = dpis_pkg::QNAN_DEF;
        else if (a_inf || b_inf)
            spec_val = {a_s ^ b_s, dpis_pkg::EXP_MAX, 52'd0};
        else
            spec_val = {a_s ^ b_s, 63'd0};
    end

    // Partial product selection: lower 27 bits or upper 26 bits of each operand.
    logic [26:0]  pa, pb;
    logic [105:0] pp_shifted;

    always_comb
    begin
        pa = k_reg[0] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        pb = k_reg[1] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp_shifted = {52'd0, pp_reg} << ({1'b0, k_reg[0]} * 7'd27 + {1'b0, k_reg[1]} * 7'd27);
    end

    // Rounding to nearest even.
    logic [52:0]        rn_mant;
    logic               rn_inc;
    logic [53:0]        rn_sum;
    logic signed [12:0] rn_exp;
    logic [51:0]        rn_frac;
    logic [63:0]        rnd_val;

    always_comb
    begin
        rn_mant = p_reg[105:53];
        rn_inc  = p_reg[52] && ((|p_reg[51:0]) || stk_reg || rn_mant[0]);
        rn_sum  = {1'b0, rn_mant} + {53'd0, rn_inc};
        if (rn_sum[53])
        begin
            rn_exp  = e_reg + 13'sd1;
            rn_frac = rn_sum[52:1];
        end
        else
        begin
            rn_exp  = rn_sum[52] ? e_reg : 13'sd0;
            rn_frac = rn_sum[51:0];
        end
        if (rn_exp >= 13'sd2047)
            rnd_val = {sgn_reg, dpis_pkg::EXP_MAX, 52'd0};
        else
            rnd_val = {sgn_reg, rn_exp[10:0], rn_frac};
    end

    // Right shift into the subnormal range with sticky collection.
    logic signed [12:0] rs_amt;
    logic [105:0]       rs_mask;
    logic [105:0]       rs_p;
    logic               rs_lost;

    always_comb
    begin
        rs_amt  = 13'sd1 - e_reg;
        rs_mask = ~({106{1'b1}} << rs_amt[6:0]);
        if (rs_amt > 13'sd106)
        begin
            rs_p    = 106'd0;
            rs_lost = |p_reg;
        end
        else
        begin
            rs_p    = p_reg >> rs_amt[6:0];
            rs_lost = |(p_reg & rs_mask);
        end
    end

    // One restoring division step.
    logic        dv_ge;
    logic [53:0] dv_rem;

    always_comb
    begin
        dv_ge  = (rem_reg >= {1'b0, md_reg});
        dv_rem = dv_ge ? (rem_reg - {1'b0, md_reg}) : rem_reg;
    end

    // Reciprocal special cases.
    logic        acc_nan, acc_inf, acc_zero;
    assign acc_zero = (acc_reg[62:0] == 63'd0);
    assign acc_nan  = (acc_reg[62:52] == dpis_pkg::EXP_MAX) && (acc_reg[51:0] != 52'd0);
    assign acc_inf  = (acc_reg[62:52] == dpis_pkg::EXP_MAX) && (acc_reg[51:0] == 52'd0);

    logic        done;
    logic [63:0] fin_val;

    always_comb
    begin
        done    = ((state_reg == dpis_pkg::S_MLOAD) && spec) ||
                  (state_reg == dpis_pkg::S_ROUND);
        fin_val = (state_reg == dpis_pkg::S_MLOAD) ? spec_val : rnd_val;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpis_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = (raw_mag == '0) ? dpis_pkg::S_OUT : dpis_pkg::S_SQR;
            end
            dpis_pkg::S_SQR:
            begin
                if (msh_reg[W-1:1] != '0)
                    state_next = dpis_pkg::S_MLOAD;
                else
                    state_next = dpis_pkg::S_ACC_RD;
            end
            dpis_pkg::S_ACC_RD:
            begin
                if (mag_reg[idx_reg])
                    state_next = dpis_pkg::S_ACC_WAIT;
                else if (idx_reg == '0)
                    state_next = dpis_pkg::S_RES;
            end
            dpis_pkg::S_ACC_WAIT: state_next = dpis_pkg::S_MLOAD;
            dpis_pkg::S_MLOAD:
            begin
                if (!spec)
                    state_next = dpis_pkg::S_MPP;
            end
            dpis_pkg::S_MPP: state_next = dpis_pkg::S_MADD;
            dpis_pkg::S_MADD:
            begin
                state_next = (k_reg == dpis_pkg::PP_LAST) ? dpis_pkg::S_NORM
                                                          : dpis_pkg::S_MPP;
            end
            dpis_pkg::S_NORM:
            begin
                if (p_reg[105] || (e_reg <= 13'sd1))
                    state_next = dpis_pkg::S_ROUND;
            end
            dpis_pkg::S_ROUND: state_next = dpis_pkg::S_ROUND;
            dpis_pkg::S_RES:
            begin
                if (!neg_reg || acc_zero || acc_nan || acc_inf)
                    state_next = dpis_pkg::S_OUT;
                else
                    state_next = dpis_pkg::S_DNORM;
            end
            dpis_pkg::S_DNORM:
            begin
                if (md_reg[52])
                    state_next = dpis_pkg::S_DIV;
            end
            dpis_pkg::S_DIV:
            begin
                if (dcnt_reg == dpis_pkg::DIV_LAST)
                    state_next = dpis_pkg::S_NORM;
            end
            dpis_pkg::S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                    state_next = dpis_pkg::S_IDLE;
            end
            default: state_next = dpis_pkg::S_IDLE;
        endcase
        // A finished multiply resumes its loop; a reciprocal goes on to output.
        if (done)
        begin
            unique case (phase_reg)
                dpis_pkg::PH_SQR: state_next = dpis_pkg::S_SQR;
                dpis_pkg::PH_ACC: state_next = (idx_reg == '0) ? dpis_pkg::S_RES
                                                               : dpis_pkg::S_ACC_RD;
                dpis_pkg::PH_DIV: state_next = dpis_pkg::S_OUT;
                default:          state_next = dpis_pkg::S_IDLE;
            endcase
        end
    end

    // Datapath.
    always_comb
    begin
        phase_next  = phase_reg;
        mag_next    = mag_reg;
        msh_next    = msh_reg;
        neg_next    = neg_reg;
        idx_next    = idx_reg;
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        k_next      = k_reg;
        pp_next     = pp_reg;
        p_next      = p_reg;
        stk_next    = stk_reg;
        e_next      = e_reg;
        sgn_next    = sgn_reg;
        md_next     = md_reg;
        ed_next     = ed_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        dcnt_next   = dcnt_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = fin_val;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            dpis_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    mag_next  = raw_mag;
                    msh_next  = raw_mag;
                    neg_next  = raw_neg;
                    idx_next  = '0;
                    sq_next   = s_tdata[63:0];
                    acc_next  = dpis_pkg::ONE_BITS;
                    res_next  = dpis_pkg::ONE_BITS;
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = s_tdata[63:0];
                end
            end
            dpis_pkg::S_SQR:
            begin
                opa_next   = sq_reg;
                opb_next   = sq_reg;
                phase_next = dpis_pkg::PH_SQR;
            end
            dpis_pkg::S_ACC_RD:
            begin
                if (!mag_reg[idx_reg] && (idx_reg != '0))
                    idx_next = idx_reg - {{(IW-1){1'b0}}, 1'b1};
            end
            dpis_pkg::S_ACC_WAIT:
            begin
                opa_next   = acc_reg;
                opb_next   = rd_reg;
                phase_next = dpis_pkg::PH_ACC;
            end
            dpis_pkg::S_MLOAD:
            begin
                ma_next  = {(a_e != 11'd0), a_f};
                mb_next  = {(b_e != 11'd0), b_f};
                e_next   = $signed({2'b00, (a_e == 11'd0) ? 11'd1 : a_e}) +
                           $signed({2'b00, (b_e == 11'd0) ? 11'd1 : b_e}) - 13'sd1022;
                sgn_next = a_s ^ b_s;
                p_next   = '0;
                stk_next = 1'b0;
                k_next   = '0;
            end
            dpis_pkg::S_MPP:
            begin
                pp_next = pa * pb;
            end
            dpis_pkg::S_MADD:
            begin
                p_next = p_reg + pp_shifted;
                k_next = k_reg + 2'd1;
            end
            dpis_pkg::S_NORM:
            begin
                if (!p_reg[105] && (e_reg > 13'sd1))
                begin
                    p_next = {p_reg[104:0], 1'b0};
                    e_next = e_reg - 13'sd1;
                end
                else if (e_reg < 13'sd1)
                begin
                    p_next   = rs_p;
                    stk_next = stk_reg | rs_lost;
                    e_next   = 13'sd1;
                end
            end
            dpis_pkg::S_ROUND:
            begin
            end
            dpis_pkg::S_RES:
            begin
                res_next = acc_reg;
                sgn_next = acc_reg[63];
                if (neg_reg)
                begin
                    priority if (acc_zero)
                        res_next = {acc_reg[63], dpis_pkg::EXP_MAX, 52'd0};
                    else if (acc_nan)
                        res_next = acc_reg | dpis_pkg::QUIET_BIT;
                    else if (acc_inf)
                        res_next = {acc_reg[63], 63'd0};
                end
                md_next   = {(acc_reg[62:52] != 11'd0), acc_reg[51:0]};
                ed_next   = $signed({2'b00, (acc_reg[62:52] == 11'd0) ? 11'd1
                                                                      : acc_reg[62:52]});
                rem_next  = {2'b01, 52'd0};
                q_next    = '0;
                dcnt_next = '0;
            end
            dpis_pkg::S_DNORM:
            begin
                if (!md_reg[52])
                begin
                    md_next = {md_reg[51:0], 1'b0};
                    ed_next = ed_reg - 13'sd1;
                end
            end
            dpis_pkg::S_DIV:
            begin
                q_next    = {q_reg[53:0], dv_ge};
                rem_next  = {dv_rem[52:0], 1'b0};
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == dpis_pkg::DIV_LAST)
                begin
                    // The quotient of 2^106 by the significand, aligned to the top.
                    p_next     = {q_reg[53:0], dv_ge, 51'd0};
                    stk_next   = (dv_rem != 54'd0);
                    e_next     = 13'sd2046 - ed_reg;
                    phase_next = dpis_pkg::PH_DIV;
                end
            end
            dpis_pkg::S_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (done)
        begin
            unique case (phase_reg)
                dpis_pkg::PH_SQR:
                begin
                    sq_next   = fin_val;
                    idx_next  = idx_reg + {{(IW-1){1'b0}}, 1'b1};
                    msh_next  = msh_reg >> 1;
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg + {{(IW-1){1'b0}}, 1'b1};
                end
                dpis_pkg::PH_ACC:
                begin
                    acc_next = fin_val;
                    if (idx_reg != '0)
                        idx_next = idx_reg - {{(IW-1){1'b0}}, 1'b1};
                end
                dpis_pkg::PH_DIV:
                begin
                    res_next = fin_val;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dpis_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        mag_reg   <= mag_next;
        msh_reg   <= msh_next;
        neg_reg   <= neg_next;
        idx_reg   <= idx_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        k_reg     <= k_next;
        pp_reg    <= pp_next;
        p_reg     <= p_next;
        stk_reg   <= stk_next;
        e_reg     <= e_next;
        sgn_reg   <= sgn_next;
        md_reg    <= md_next;
        ed_reg    <= ed_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        dcnt_reg  <= dcnt_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
    end

    // Term store: base squared i times lives at entry i.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            term_mem[mem_waddr] <= mem_wdata;
        rd_reg <= term_mem[idx_reg];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != dpis_pkg::S_IDLE))
        else $error("sequencer stayed idle after taking an item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dpis_pkg::S_ROUND) |-> (e_reg >= 13'sd1))
        else $error("rounding entered with exponent below the subnormal floor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dpis_pkg::S_ACC_WAIT) |-> mag_reg[idx_reg])
        else $error("term fetched for a clear exponent bit");

endmodule
`default_nettype wire
